// ===== rtl/mdhr_pkg.sv =====
// mdhr_pkg: types and constants shared by the motion detect / hold / rate block
// sample and result words, configuration registers, register indexes and reset values
// no dependencies
package mdhr_pkg;

	// register index codes on the configuration port
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GYRO_THRESHOLD  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_RATE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_RATE       = 3'd4;

	// register reset values
	localparam logic [14:0] ACCEL_THRESHOLD_RST = 15'd25;
	localparam logic [14:0] GYRO_THRESHOLD_RST  = 15'd10;
	localparam logic [14:0] HOLD_TICKS_RST      = 15'd60;
	localparam logic [15:0] ACTIVE_RATE_RST     = 16'd10;
	localparam logic [15:0] IDLE_RATE_RST       = 16'd100;

	// one sensor tick
	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
	} sample_t;

	// one result word
	typedef struct packed {
		logic        motion_seen;
		logic        active;
		logic        rate_change;
		logic [15:0] new_rate;
	} result_t;

	// accelerometer sample of the previous tick
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} accel_vec_t;

	// configuration register set
	typedef struct packed {
		logic [14:0] accel_threshold;
		logic [14:0] gyro_threshold;
		logic [14:0] hold_ticks;
		logic [15:0] active_rate;
		logic [15:0] idle_rate;
	} cfg_t;

endpackage

// ===== rtl/motion_detect_hold_rate.sv =====
// motion_detect_hold_rate: top level of the motion detect / hold / rate block
// input register, configuration registers, detect and hold logic, result register
// depends on mdhr_pkg, mdhr_detect, mdhr_hold
//
// Takes one sensor tick per clock cycle when not stalled and gives one result per tick, in order.
// The tick is held in the input register, and its result loads into the result register
// when stage 1 advances, which a stall of the result register can hold off.
// Input stalls only while the result register holds a word that is not taken.
// The whole tick update (accel difference compares, gyro magnitude compares, hold
// counter and flag) is done combinationally between those registers, so a tick sees the
// state left by the tick before it. Configuration writes take effect for ticks
// processed afterwards and are expected only while no tick is in flight. No clearing
// pass after reset.
module motion_detect_hold_rate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mdhr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mdhr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mdhr_pkg::sample_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mdhr_pkg::result_t                 out_data
);
	import mdhr_pkg::*;

	cfg_t       cfg_q;
	sample_t    sample_s1;
	logic       valid_s1;
	result_t    out_q;
	logic       out_valid_q;

	logic       adv_s1;
	logic       motion;
	logic       active;
	accel_vec_t prev_accel;
	result_t    result;

	// configuration registers, masked to width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_threshold <= ACCEL_THRESHOLD_RST;
			cfg_q.gyro_threshold  <= GYRO_THRESHOLD_RST;
			cfg_q.hold_ticks      <= HOLD_TICKS_RST;
			cfg_q.active_rate     <= ACTIVE_RATE_RST;
			cfg_q.idle_rate       <= IDLE_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEL_THRESHOLD: cfg_q.accel_threshold <= cfg_data[14:0];
				REG_GYRO_THRESHOLD:  cfg_q.gyro_threshold  <= cfg_data[14:0];
				REG_HOLD_TICKS:      cfg_q.hold_ticks      <= cfg_data[14:0];
				REG_ACTIVE_RATE:     cfg_q.active_rate     <= cfg_data;
				REG_IDLE_RATE:       cfg_q.idle_rate       <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or drains
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_data;
		end
	end

	// threshold compare
	mdhr_detect u_detect (
		.sample     (sample_s1),
		.prev_accel (prev_accel),
		.cfg        (cfg_q),
		.motion     (motion)
	);

	// tick state and result
	mdhr_hold u_hold (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.sample     (sample_s1),
		.motion     (motion),
		.cfg        (cfg_q),
		.prev_accel (prev_accel),
		.active     (active),
		.result     (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a tick with motion always leaves the block active
	a_motion_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.motion_seen || out_q.active))
		else $error("motion seen without active flag");

	// rate change flag matches the flag transition of the same tick
	a_rate_change: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (out_q.rate_change == (active != $past(active))))
		else $error("rate change does not match flag transition");

	// reported flag is the state the tick left behind
	a_flag_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (out_q.active == active))
		else $error("result flag differs from held flag");

	// input held off only while stage 1 is occupied
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled with empty stage");

endmodule

// ===== rtl/mdhr_detect.sv =====
// mdhr_detect: threshold compare for one sensor tick
// accel change against the previous tick, gyro magnitude against its threshold
// depends on mdhr_pkg
module mdhr_detect (
	input  mdhr_pkg::sample_t    sample,
	input  mdhr_pkg::accel_vec_t prev_accel,
	input  mdhr_pkg::cfg_t       cfg,
	output logic                 motion
);
	import mdhr_pkg::*;

	logic [16:0] accel_mag [3];
	logic [15:0] gyro_mag [3];
	logic [2:0]  accel_hit;
	logic [2:0]  gyro_hit;

	// 17-bit magnitude of a difference, no wrap
	function automatic logic [16:0] diff_mag(input logic signed [15:0] now_v,
			input logic signed [15:0] old_v);
		logic signed [16:0] d;
		d = {now_v[15], now_v} - {old_v[15], old_v};
		diff_mag = d[16] ? 17'(-d) : 17'(d);
	endfunction

	// 16-bit magnitude, -32768 gives 32768
	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		abs16 = v[15] ? 16'(-v) : 16'(v);
	endfunction

	// per-axis magnitudes
	always_comb begin
		accel_mag[0] = diff_mag(sample.accel_x, prev_accel.x);
		accel_mag[1] = diff_mag(sample.accel_y, prev_accel.y);
		accel_mag[2] = diff_mag(sample.accel_z, prev_accel.z);
		gyro_mag[0]  = abs16(sample.gyro_x);
		gyro_mag[1]  = abs16(sample.gyro_y);
		gyro_mag[2]  = abs16(sample.gyro_z);
	end

	// threshold compares
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			accel_hit[i] = accel_mag[i] > {2'b00, cfg.accel_threshold};
			gyro_hit[i]  = gyro_mag[i] > {1'b0, cfg.gyro_threshold};
		end
	end

	assign motion = (|accel_hit) | (|gyro_hit);

endmodule

// ===== rtl/mdhr_hold.sv =====
// mdhr_hold: tick state and result forming
// previous accel sample, hold counter and active flag, updated once per tick
// depends on mdhr_pkg
module mdhr_hold (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  mdhr_pkg::sample_t    sample,
	input  logic                 motion,
	input  mdhr_pkg::cfg_t       cfg,
	output mdhr_pkg::accel_vec_t prev_accel,
	output logic                 active,
	output mdhr_pkg::result_t    result
);
	import mdhr_pkg::*;

	accel_vec_t         prev_accel_q;
	logic signed [15:0] hold_count_q;
	logic               active_q;

	logic signed [15:0] hold_next;
	logic               active_next;

	// counter load on motion, else count down and stop at -1
	always_comb begin
		if (motion) begin
			hold_next   = {1'b0, cfg.hold_ticks};
			active_next = 1'b1;
		end else begin
			hold_next   = hold_count_q[15] ? hold_count_q : hold_count_q - 16'sd1;
			active_next = hold_next[15] ? 1'b0 : active_q;
		end
	end

	// state update when a tick is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_accel_q <= '0;
			hold_count_q <= '0;
			active_q     <= 1'b0;
		end else if (step) begin
			prev_accel_q.x <= sample.accel_x;
			prev_accel_q.y <= sample.accel_y;
			prev_accel_q.z <= sample.accel_z;
			hold_count_q   <= hold_next;
			active_q       <= active_next;
		end
	end

	// result of the tick being processed
	always_comb begin
		result.motion_seen = motion;
		result.active      = active_next;
		result.rate_change = active_next ^ active_q;
		result.new_rate    = active_next ? cfg.active_rate : cfg.idle_rate;
	end

	assign prev_accel = prev_accel_q;
	assign active     = active_q;

endmodule
